@@ src/psdc_pkg.sv @@
// Shared types, constants, key table and decrypt function of the stream decrypt checker.
package psdc_pkg;

  // Frame size limits.
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned MAX_FRAME    = 8192;

  // Odd-position key entries held in the key stream RAM.
  localparam int unsigned KEY_DEPTH = 256;

  // Configuration register indexes.
  localparam logic [0:0] CFG_NEED_INIT = 1'b0;
  localparam logic [0:0] CFG_INIT_CODE = 1'b1;

  // Status codes of a result.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_BAD_INIT = 2'd3
  } status_t;

  // What a byte turned out to be when it was parsed.
  typedef enum logic [2:0] {
    KIND_INIT     = 3'd0,
    KIND_INIT_BAD = 3'd1,
    KIND_SIZE_BAD = 3'd2,
    KIND_BYTE     = 3'd3,
    KIND_END      = 3'd4
  } kind_t;

  // Parser result handed to the decrypt stage.
  typedef struct packed {
    kind_t       kind;
    logic        body;
    logic        clr;
    logic [1:0]  phase;
    logic [7:0]  rx;
    logic [7:0]  check;
    logic [31:0] info;
  } stage_t;

  // Fixed key table: even entries give the start position, odd entries the key stream.
  localparam logic [7:0] KEY_ROM [0:511] = '{
    8'h84, 8'h87, 8'h37, 8'hd7, 8'hea, 8'h79, 8'h91, 8'h7d,
    8'h4b, 8'h4b, 8'h85, 8'h7d, 8'h87, 8'h81, 8'h91, 8'h7c,
    8'h0f, 8'h73, 8'h91, 8'h91, 8'h87, 8'h7d, 8'h0d, 8'h7d,
    8'h86, 8'h8f, 8'h73, 8'h0f, 8'he1, 8'hdd, 8'h85, 8'h7d,
    8'h05, 8'h7d, 8'h85, 8'h83, 8'h87, 8'h9c, 8'h85, 8'h33,
    8'h0d, 8'he2, 8'h87, 8'h19, 8'h0f, 8'h79, 8'h85, 8'h86,
    8'h37, 8'h7d, 8'hd7, 8'hdd, 8'he9, 8'h7d, 8'hd7, 8'h7d,
    8'h85, 8'h79, 8'h05, 8'h7d, 8'h0f, 8'he1, 8'h87, 8'h7e,
    8'h23, 8'h87, 8'hf5, 8'h79, 8'h5f, 8'he3, 8'h4b, 8'h83,
    8'ha3, 8'ha2, 8'hae, 8'h0e, 8'h14, 8'h7d, 8'hde, 8'h7e,
    8'h85, 8'h7a, 8'h85, 8'haf, 8'hcd, 8'h7d, 8'h87, 8'ha5,
    8'h87, 8'h7d, 8'he1, 8'h7d, 8'h88, 8'h7d, 8'h15, 8'h91,
    8'h23, 8'h7d, 8'h87, 8'h7c, 8'h0d, 8'h7a, 8'h85, 8'h87,
    8'h17, 8'h7c, 8'h85, 8'h7d, 8'hac, 8'h80, 8'hbb, 8'h79,
    8'h84, 8'h9b, 8'h5b, 8'ha5, 8'hd7, 8'h8f, 8'h05, 8'h0f,
    8'h85, 8'h7e, 8'h85, 8'h80, 8'h85, 8'h98, 8'hf5, 8'h9d,
    8'ha3, 8'h1a, 8'h0d, 8'h19, 8'h87, 8'h7c, 8'h85, 8'h7d,
    8'h84, 8'h7d, 8'h85, 8'h7e, 8'he7, 8'h97, 8'h0d, 8'h0f,
    8'h85, 8'h7b, 8'hea, 8'h7d, 8'had, 8'h80, 8'had, 8'h7d,
    8'hb7, 8'haf, 8'h0d, 8'h7d, 8'he9, 8'h3d, 8'h85, 8'h7d,
    8'h87, 8'hb7, 8'h23, 8'h7d, 8'he7, 8'hb7, 8'ha3, 8'h0c,
    8'h87, 8'h7e, 8'h85, 8'ha5, 8'h7d, 8'h76, 8'h35, 8'hb9,
    8'h0d, 8'h6f, 8'h23, 8'h7d, 8'h87, 8'h9b, 8'h85, 8'h0c,
    8'he1, 8'ha1, 8'h0d, 8'h7f, 8'h87, 8'h7d, 8'h84, 8'h7a,
    8'h84, 8'h7b, 8'he1, 8'h86, 8'he8, 8'h6f, 8'hd1, 8'h79,
    8'h85, 8'h19, 8'h53, 8'h95, 8'hc3, 8'h47, 8'h19, 8'h7d,
    8'he7, 8'h0c, 8'h37, 8'h7c, 8'h23, 8'h7d, 8'h85, 8'h7d,
    8'h4b, 8'h79, 8'h21, 8'ha5, 8'h87, 8'h7d, 8'h19, 8'h7d,
    8'h0d, 8'h7d, 8'h15, 8'h91, 8'h23, 8'h7d, 8'h87, 8'h7c,
    8'h85, 8'h7a, 8'h85, 8'haf, 8'hcd, 8'h7d, 8'h87, 8'h7d,
    8'he9, 8'h3d, 8'h85, 8'h7d, 8'h15, 8'h79, 8'h85, 8'h7d,
    8'hc1, 8'h7b, 8'hea, 8'h7d, 8'hb7, 8'h7d, 8'h85, 8'h7d,
    8'h85, 8'h7d, 8'h0d, 8'h7d, 8'he9, 8'h73, 8'h85, 8'h79,
    8'h05, 8'h7d, 8'hd7, 8'h7d, 8'h85, 8'he1, 8'hb9, 8'he1,
    8'h0f, 8'h65, 8'h85, 8'h86, 8'h2d, 8'h7d, 8'hd7, 8'hdd,
    8'ha3, 8'h8e, 8'he6, 8'h7d, 8'hde, 8'h7e, 8'hae, 8'h0e,
    8'h0f, 8'he1, 8'h89, 8'h7e, 8'h23, 8'h7d, 8'hf5, 8'h79,
    8'h23, 8'he1, 8'h4b, 8'h83, 8'h0c, 8'h0f, 8'h85, 8'h7b,
    8'h85, 8'h7e, 8'h8f, 8'h80, 8'h85, 8'h98, 8'hf5, 8'h7a,
    8'h85, 8'h1a, 8'h0d, 8'he1, 8'h0f, 8'h7c, 8'h89, 8'h0c,
    8'h85, 8'h0b, 8'h23, 8'h69, 8'h87, 8'h7b, 8'h23, 8'h0c,
    8'h1f, 8'hb7, 8'h21, 8'h7a, 8'h88, 8'h7e, 8'h8f, 8'ha5,
    8'h7d, 8'h80, 8'hb7, 8'hb9, 8'h18, 8'hbf, 8'h4b, 8'h19,
    8'h85, 8'ha5, 8'h91, 8'h80, 8'h87, 8'h81, 8'h87, 8'h7c,
    8'h0f, 8'h73, 8'h91, 8'h91, 8'h84, 8'h87, 8'h37, 8'hd7,
    8'h86, 8'h79, 8'he1, 8'hdd, 8'h85, 8'h7a, 8'h73, 8'h9b,
    8'h05, 8'h7d, 8'h0d, 8'h83, 8'h87, 8'h9c, 8'h85, 8'h33,
    8'h87, 8'h7d, 8'h85, 8'h0f, 8'h87, 8'h7d, 8'h0d, 8'h7d,
    8'hf6, 8'h7e, 8'h87, 8'h7d, 8'h88, 8'h19, 8'h89, 8'hf5,
    8'hd1, 8'hdd, 8'h85, 8'h7d, 8'h8b, 8'hc3, 8'hea, 8'h7a,
    8'hd7, 8'hb0, 8'h0d, 8'h7d, 8'h87, 8'ha5, 8'h87, 8'h7c,
    8'h73, 8'h7e, 8'h7d, 8'h86, 8'h87, 8'h23, 8'h85, 8'h10,
    8'hd7, 8'hdf, 8'hed, 8'ha5, 8'he1, 8'h7a, 8'h85, 8'h23,
    8'hea, 8'h7e, 8'h85, 8'h98, 8'had, 8'h79, 8'h86, 8'h7d,
    8'h85, 8'h7d, 8'hd7, 8'h7d, 8'he1, 8'h7a, 8'hf5, 8'h7d,
    8'h85, 8'hb0, 8'h2b, 8'h37, 8'he1, 8'h7a, 8'h87, 8'h79,
    8'h84, 8'h7d, 8'h73, 8'h73, 8'h87, 8'h7d, 8'h23, 8'h7d,
    8'he9, 8'h7d, 8'h85, 8'h7e, 8'h02, 8'h7d, 8'hdd, 8'h2d,
    8'h87, 8'h79, 8'he7, 8'h79, 8'had, 8'h7c, 8'h23, 8'hda,
    8'h87, 8'h0d, 8'h0d, 8'h7b, 8'he7, 8'h79, 8'h9b, 8'h7d,
    8'hd7, 8'h8f, 8'h05, 8'h7d, 8'h0d, 8'h34, 8'h8f, 8'h7d,
    8'had, 8'h87, 8'he9, 8'h7c, 8'h85, 8'h80, 8'h85, 8'h79,
    8'h8a, 8'hc3, 8'he7, 8'ha5, 8'he8, 8'h6b, 8'h0d, 8'h74,
    8'h10, 8'h73, 8'h33, 8'h17, 8'h0d, 8'h37, 8'h21, 8'h19
  };

  // Start position chosen by a key index byte.
  function automatic logic [7:0] key_start(input logic [7:0] key_idx);
    return KEY_ROM[{key_idx, 1'b0}];
  endfunction

  // Key stream entry at a position.
  function automatic logic [7:0] key_trans(input logic [7:0] pos);
    return KEY_ROM[{pos, 1'b1}];
  endfunction

  // Decrypt one body byte; the phase is the low two bits of its frame position.
  function automatic logic [7:0] decrypt(input logic [7:0] b, input logic [1:0] phase,
                                         input logic [7:0] trans);
    logic [7:0] res;
    unique case (phase)
      2'd0:    res = b - {trans[6:0], 1'b0};
      2'd1:    res = b + {3'b000, trans[7:3]};
      2'd2:    res = b - {trans[5:0], 2'b00};
      default: res = b + {5'b00000, trans[7:5]};
    endcase
    return res;
  endfunction

endpackage

@@ src/psdc_ram.sv @@
// Generic single-port-write, registered-read RAM.
module psdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is requested.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/psdc_parse.sv @@
// Header and init word parser: tracks the frame position and classifies each byte.
module psdc_parse #(
  parameter int unsigned HEADER_BYTES = psdc_pkg::HEADER_BYTES,
  parameter int unsigned MAX_FRAME    = psdc_pkg::MAX_FRAME
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [31:0]           cfg_wdata,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  output psdc_pkg::stage_t      st,
  output logic [7:0]            key_addr
);

  logic        need_init_r;
  logic [31:0] init_code_r;
  logic        init_done_r, init_done_nxt;
  logic [31:0] init_shift_r, init_shift_nxt;
  logic [15:0] byte_index_r, byte_index_nxt;
  logic [15:0] frame_size_r, frame_size_nxt;
  logic [7:0]  key_pos_r, key_pos_nxt;
  logic [7:0]  check_byte_r, check_byte_nxt;
  logic [16:0] idx_inc;
  logic [15:0] size_word;
  logic        size_bad;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_init_r <= 1'b1;
      init_code_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psdc_pkg::CFG_NEED_INIT: need_init_r <= cfg_wdata[0];
        psdc_pkg::CFG_INIT_CODE: init_code_r <= cfg_wdata;
        default:                 init_code_r <= init_code_r;
      endcase
    end
  end

  // The size as it stands once its second byte is in.
  assign idx_inc   = {1'b0, byte_index_r} + 17'd1;
  assign key_addr  = key_pos_r;
  assign size_word = {rx_byte, frame_size_r[7:0]};
  assign size_bad  = (size_word < 16'(HEADER_BYTES)) || (size_word < 16'd4) ||
                     (size_word >= 16'(MAX_FRAME));

  // Parse one byte against the current frame position.
  always_comb begin
    init_done_nxt  = init_done_r;
    init_shift_nxt = init_shift_r;
    byte_index_nxt = idx_inc[15:0];
    frame_size_nxt = frame_size_r;
    key_pos_nxt    = key_pos_r;
    check_byte_nxt = check_byte_r;
    st.kind  = psdc_pkg::KIND_BYTE;
    st.body  = 1'b0;
    st.clr   = 1'b0;
    st.phase = byte_index_r[1:0];
    st.rx    = rx_byte;
    st.check = check_byte_r;
    st.info  = '0;
    if (need_init_r && !init_done_r) begin
      // Collect the init word, newest byte on top.
      init_shift_nxt = {rx_byte, init_shift_r[31:8]};
      st.kind        = psdc_pkg::KIND_INIT;
      if (idx_inc >= 17'd4) begin
        byte_index_nxt = '0;
        if (init_shift_nxt == init_code_r) begin
          init_done_nxt = 1'b1;
        end else begin
          st.kind = psdc_pkg::KIND_INIT_BAD;
          st.info = init_shift_nxt;
        end
      end
    end else begin
      priority case (1'b1)
        byte_index_r == 16'd0: begin
          frame_size_nxt = {8'h00, rx_byte};
          st.clr         = 1'b1;
        end
        byte_index_r == 16'd1: begin
          frame_size_nxt = size_word;
        end
        byte_index_r == 16'd2: begin
          key_pos_nxt = psdc_pkg::key_start(rx_byte);
        end
        byte_index_r == 16'd3: begin
          check_byte_nxt = rx_byte;
        end
        default: begin
          st.body     = 1'b1;
          key_pos_nxt = key_pos_r + 8'd1;
        end
      endcase
      st.check = check_byte_nxt;
      st.info  = {16'h0000, frame_size_nxt};
      if ((byte_index_r == 16'd1) && size_bad) begin
        byte_index_nxt = '0;
        st.kind        = psdc_pkg::KIND_SIZE_BAD;
      end else if ((byte_index_r >= 16'd3) && (idx_inc >= {1'b0, frame_size_nxt})) begin
        byte_index_nxt = '0;
        st.kind        = psdc_pkg::KIND_END;
      end
    end
  end

  // Parser state advances on each accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_done_r  <= 1'b0;
      init_shift_r <= '0;
      byte_index_r <= '0;
      frame_size_r <= '0;
      key_pos_r    <= '0;
      check_byte_r <= '0;
    end else if (accept) begin
      init_done_r  <= init_done_nxt;
      init_shift_r <= init_shift_nxt;
      byte_index_r <= byte_index_nxt;
      frame_size_r <= frame_size_nxt;
      key_pos_r    <= key_pos_nxt;
      check_byte_r <= check_byte_nxt;
    end
  end

endmodule

@@ src/psdc_dec.sv @@
// Decrypt stage with running sums, checksum test and the output register.
module psdc_dec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  psdc_pkg::stage_t st,
  input  logic [7:0]       trans,
  output logic             adv,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_frame_last,
  output logic [1:0]       out_status,
  output logic [31:0]      out_error_info
);

  logic             s1_valid_r;
  psdc_pkg::stage_t s1_r;
  logic [7:0]       raw_sum_r, raw_sum_nxt;
  logic [7:0]       plain_sum_r, plain_sum_nxt;
  logic [7:0]       ob;
  logic             mism;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             byte_valid_r, byte_valid_nxt;
  logic             frame_last_r, frame_last_nxt;
  psdc_pkg::status_t status_r, status_nxt;
  logic [31:0]      error_info_r, error_info_nxt;

  // Both stages move whenever the output register is free or being taken.
  assign adv = !out_valid_r || out_ready;

  // Parsed byte register; the key stream RAM read lines up with it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && accept) begin
      s1_r <= st;
    end
  end

  // Decrypt and fold the byte into the running sums.
  always_comb begin
    ob            = s1_r.body ? psdc_pkg::decrypt(s1_r.rx, s1_r.phase, trans) : s1_r.rx;
    raw_sum_nxt   = (s1_r.clr ? 8'h00 : raw_sum_r) + (s1_r.body ? s1_r.rx : 8'h00);
    plain_sum_nxt = (s1_r.clr ? 8'h00 : plain_sum_r) + (s1_r.body ? ob : 8'h00);
    mism          = (raw_sum_nxt - plain_sum_nxt) != s1_r.check;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_sum_r   <= '0;
      plain_sum_r <= '0;
    end else if (adv && s1_valid_r) begin
      raw_sum_r   <= raw_sum_nxt;
      plain_sum_r <= plain_sum_nxt;
    end
  end

  // Result flags from the byte class.
  always_comb begin
    byte_valid_nxt = 1'b1;
    frame_last_nxt = 1'b0;
    status_nxt     = psdc_pkg::ST_OK;
    error_info_nxt = '0;
    unique case (s1_r.kind)
      psdc_pkg::KIND_INIT: begin
        byte_valid_nxt = 1'b0;
      end
      psdc_pkg::KIND_INIT_BAD: begin
        byte_valid_nxt = 1'b0;
        frame_last_nxt = 1'b1;
        status_nxt     = psdc_pkg::ST_BAD_INIT;
        error_info_nxt = s1_r.info;
      end
      psdc_pkg::KIND_SIZE_BAD: begin
        frame_last_nxt = 1'b1;
        status_nxt     = psdc_pkg::ST_BAD_SIZE;
        error_info_nxt = s1_r.info;
      end
      psdc_pkg::KIND_END: begin
        frame_last_nxt = 1'b1;
        if (mism) begin
          status_nxt     = psdc_pkg::ST_CHECKSUM;
          error_info_nxt = s1_r.info;
        end
      end
      default: begin
        frame_last_nxt = 1'b0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_byte_r   <= ob;
      byte_valid_r <= byte_valid_nxt;
      frame_last_r <= frame_last_nxt;
      status_r     <= status_nxt;
      error_info_r <= error_info_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = byte_valid_r;
  assign out_frame_last = frame_last_r;
  assign out_status     = status_r;
  assign out_error_info = error_info_r;

`ifndef NO_ASSERTIONS
  // A parsed byte is never dropped while the output is stalled.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r)
    else $error("parsed byte lost during stall");

  // Any non-zero status closes a frame or an init word.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != psdc_pkg::ST_OK) |-> frame_last_r)
    else $error("error status without frame_last");

  // Init bytes carry either no status or a bad init code.
  a_init_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !byte_valid_r |->
      (status_r == psdc_pkg::ST_OK) || (status_r == psdc_pkg::ST_BAD_INIT))
    else $error("init byte with frame status");
`endif

endmodule

@@ src/packet_stream_decrypt_check.sv @@
// Top level of the stream decrypt checker: key stream RAM fill, parser and decrypt stage.
// A byte accepted on the input passes the parsed byte register, then the output register.
// Throughput: one byte per cycle while the output register is free or being taken.
// The output register frees the input side whenever the result is taken or empty.
// Reset (synchronous, active low) clears the parse state and starts a fill of all 256 entries
// of the key stream RAM; no byte is accepted until it ends, configuration writes are.
module packet_stream_decrypt_check #(
  parameter int unsigned HEADER_BYTES = psdc_pkg::HEADER_BYTES,
  parameter int unsigned MAX_FRAME    = psdc_pkg::MAX_FRAME
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_frame_last,
  output logic [1:0]  out_status,
  output logic [31:0] out_error_info
);

  localparam int unsigned KEY_AW = $clog2(psdc_pkg::KEY_DEPTH);

  logic [KEY_AW:0]   fill_cnt_r;
  logic              fill_done;
  logic              accept;
  logic              adv;
  logic [7:0]        key_addr;
  logic [7:0]        trans;
  psdc_pkg::stage_t  st;

  // Fill sweep: copies the key stream entries into the RAM after reset.
  assign fill_done = fill_cnt_r[KEY_AW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
    end else if (!fill_done) begin
      fill_cnt_r <= fill_cnt_r + {{KEY_AW{1'b0}}, 1'b1};
    end
  end

  // Transfer on the input channel.
  assign in_ready = adv && fill_done;
  assign accept   = in_valid && in_ready;

  psdc_ram #(
    .WIDTH (8),
    .DEPTH (psdc_pkg::KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (!fill_done),
    .waddr (fill_cnt_r[KEY_AW-1:0]),
    .wdata (psdc_pkg::key_trans(8'(fill_cnt_r[KEY_AW-1:0]))),
    .re    (accept),
    .raddr (KEY_AW'(key_addr)),
    .rdata (trans)
  );

  psdc_parse #(
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_FRAME    (MAX_FRAME)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .st        (st),
    .key_addr  (key_addr)
  );

  psdc_dec u_dec (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .st             (st),
    .trans          (trans),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_frame_last (out_frame_last),
    .out_status     (out_status),
    .out_error_info (out_error_info)
  );

`ifndef NO_ASSERTIONS
  // No byte is taken while the key stream RAM is still being filled.
  a_fill_block: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_done |-> !in_ready)
    else $error("input accepted during key fill");

  // The fill sweep, once finished, stays finished.
  a_fill_stays: assert property (@(posedge clk) disable iff (!rst_n)
    fill_done |=> fill_done)
    else $error("key fill restarted without reset");

  // A result can only appear after an accepted byte has passed the parsed byte register.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(accept, 2))
    else $error("result without an accepted byte");
`endif

endmodule

@@ verif/packet_stream_decrypt_check_test.sv @@
// Self-checking testbench of the packet stream decrypt checker.
module packet_stream_decrypt_check_test;

  // One output transfer as the block should present it.
  typedef struct packed {
    logic [7:0]        data;
    logic              frame_byte;
    logic              last;
    psdc_pkg::status_t status;
    logic [31:0]       info;
  } result_t;

  // A line of the directed script: either a byte to send or a register setting.
  typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;
    logic        need;
    logic [31:0] code;
    bit          typed;
    result_t     want;
  } row_t;

  localparam result_t NO_RESULT = '0;
  localparam int unsigned RUN_LIMIT = 15_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = psdc_pkg::CFG_NEED_INIT;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_frame_last;
  logic [1:0]  out_status;
  logic [31:0] out_error_info;

  packet_stream_decrypt_check dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_frame_last (out_frame_last),
    .out_status     (out_status),
    .out_error_info (out_error_info)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies and parse state of the predictor, all at their reset values.
  logic        mode_init = 1'b1;
  logic [31:0] code_cfg = '0;
  logic        init_seen = 1'b0;
  logic [31:0] init_word = '0;
  logic [15:0] frame_pos = '0;
  logic [15:0] frame_len = '0;
  logic [7:0]  key_at = '0;
  logic [7:0]  check_val = '0;
  logic [7:0]  sum_raw = '0;
  logic [7:0]  sum_plain = '0;

  result_t     expected_results [$];
  bit          in_gaps = 1'b1;
  bit          out_stalls = 1'b1;
  int unsigned stall_left = 0;
  int unsigned sent_bytes = 0;
  int unsigned settings_count = 0;
  int unsigned fault_count = 0;
  int unsigned frames_closed = 0;
  int unsigned checksum_errors = 0;
  int unsigned size_errors = 0;
  int unsigned init_errors = 0;

  // Undo the key stream on one body byte; the phase is its frame position modulo four.
  function automatic logic [7:0] unscramble(input logic [7:0] b, input logic [1:0] phase,
                                            input logic [7:0] trans);
    case (phase)
      2'd0:    return b - (trans << 1);
      2'd1:    return b + (trans >> 3);
      2'd2:    return b - (trans << 2);
      default: return b + (trans >> 5);
    endcase
  endfunction

  // Advance the predicted parse state by one received byte and give its result.
  function automatic result_t decode_byte(input logic [7:0] b);
    result_t     r;
    int unsigned pos;
    logic [7:0]  ob;
    r = '{b, 1'b1, 1'b0, psdc_pkg::ST_OK, 32'h0};
    pos = {16'h0, frame_pos};
    ob = b;
    // Collect the init word, newest byte at the top.
    if (mode_init && !init_seen) begin
      init_word = {b, init_word[31:8]};
      r.frame_byte = 1'b0;
      pos = pos + 1;
      if (pos >= 4) begin
        frame_pos = '0;
        if (init_word == code_cfg) begin
          init_seen = 1'b1;
        end else begin
          r.last = 1'b1;
          r.status = psdc_pkg::ST_BAD_INIT;
          r.info = init_word;
        end
      end else begin
        frame_pos = 16'(pos);
      end
      return r;
    end
    // Header fields, then the body with its running sums.
    if (pos == 0) begin
      frame_len = {8'h00, b};
      sum_raw = '0;
      sum_plain = '0;
    end else if (pos == 1) begin
      frame_len[15:8] = b;
      if (frame_len < 16'(psdc_pkg::HEADER_BYTES) ||
          frame_len >= 16'(psdc_pkg::MAX_FRAME)) begin
        frame_pos = '0;
        r.last = 1'b1;
        r.status = psdc_pkg::ST_BAD_SIZE;
        r.info = {16'h0, frame_len};
        return r;
      end
    end else if (pos == 2) begin
      key_at = psdc_pkg::KEY_ROM[{b, 1'b0}];
    end else if (pos == 3) begin
      check_val = b;
    end else begin
      ob = unscramble(b, pos[1:0], psdc_pkg::KEY_ROM[{key_at, 1'b1}]);
      key_at = key_at + 8'd1;
      sum_raw = sum_raw + b;
      sum_plain = sum_plain + ob;
    end
    r.data = ob;
    // Close the frame and check the sums.
    if (pos >= 3 && pos + 1 >= {16'h0, frame_len}) begin
      frame_pos = '0;
      r.last = 1'b1;
      if (8'(sum_raw - sum_plain) != check_val) begin
        r.status = psdc_pkg::ST_CHECKSUM;
        r.info = {16'h0, frame_len};
      end
      return r;
    end
    frame_pos = 16'(pos + 1);
    return r;
  endfunction

  // Queue the expected result and hold the byte on the input until its transfer.
  task automatic drive_byte(input logic [7:0] b, input result_t want);
    expected_results.push_back(want);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive_byte(b, decode_byte(b));
  endtask

  // Let every outstanding result drain, then let the clock run on for the settle argument.
  task automatic wait_drained(input int unsigned settle);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Both registers are written back to back while the block is idle.
  task automatic write_config(input logic need, input logic [31:0] code);
    wait_drained(4);
    cfg_we <= 1'b1;
    cfg_index <= psdc_pkg::CFG_NEED_INIT;
    cfg_wdata <= {31'h0, need};
    @(posedge clk);
    cfg_index <= psdc_pkg::CFG_INIT_CODE;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_init = need;
    code_cfg = code;
    settings_count++;
  endtask

  // Feed filler until the parser is back at the start of a frame or init word.
  // A filler of all ones as the second size byte always gives a bad size.
  task automatic resync();
    while (frame_pos != 0) send_byte(frame_pos == 1 ? 8'hFF : 8'($urandom));
  endtask

  // One frame with random key and body; the check byte is right most of the time.
  task automatic send_frame(input int unsigned len, input bit cut);
    logic [7:0]  data [$];
    logic [7:0]  key, at, raw, plain, b;
    int unsigned n;
    key = 8'($urandom);
    at = psdc_pkg::KEY_ROM[{key, 1'b0}];
    raw = '0;
    plain = '0;
    data = {8'(len), 8'(len >> 8), key, 8'h00};
    for (int i = 4; i < len; i++) begin
      b = 8'($urandom);
      data.push_back(b);
      raw = raw + b;
      plain = plain + unscramble(b, 2'(i), psdc_pkg::KEY_ROM[{at, 1'b1}]);
      at = at + 8'd1;
    end
    data[3] = ($urandom_range(0, 9) < 7) ? 8'(raw - plain) : 8'($urandom);
    n = cut ? $urandom_range(2, len - 1) : len;
    for (int i = 0; i < n; i++) send_byte(data[i]);
  endtask

  // One unit of stream: an init word while one is awaited, else a frame or noise.
  task automatic stream_unit(input bit cut);
    int unsigned pick, n;
    logic [31:0] word;
    logic [15:0] bad;
    pick = $urandom_range(0, 99);
    resync();
    if (mode_init && !init_seen) begin
      // Wrong words only: random ones and near misses of the expected code.
      word = (pick < 50) ? $urandom : code_cfg ^ (32'h1 << $urandom_range(0, 31));
      n = cut ? $urandom_range(1, 3) : 4;
      for (int i = 0; i < n; i++) send_byte(word[8*i +: 8]);
    end else if (pick < 15) begin
      // Before the init word only short sizes, so a stale size stays small.
      if (!init_seen || pick < 8)
        bad = 16'($urandom_range(0, psdc_pkg::HEADER_BYTES - 1));
      else
        bad = 16'($urandom_range(psdc_pkg::MAX_FRAME, 65535));
      send_byte(bad[7:0]);
      send_byte(bad[15:8]);
    end else if (pick < 20) begin
      send_byte(8'($urandom));
    end else begin
      if ($urandom_range(0, 9) == 0)
        n = $urandom_range(41, 300);
      else
        n = $urandom_range(psdc_pkg::HEADER_BYTES, 40);
      send_frame(n, cut || pick < 28);
    end
  endtask

  task automatic run_phase(input int unsigned target, input bit cut_end);
    int unsigned first;
    first = sent_bytes;
    while (sent_bytes - first < target) stream_unit(1'b0);
    if (cut_end) stream_unit(1'b1);
  endtask

  // Output back-pressure in random bursts.
  always @(posedge clk) begin
    if (out_stalls && stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (out_stalls && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every output transfer with the oldest expected result.
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_byte, out_byte_valid, out_frame_last,
              psdc_pkg::status_t'(out_status), out_error_info};
      if (expected_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("Unexpected result: byte %02h frame %0b last %0b status %0d info %08h",
                   got.data, got.frame_byte, got.last, got.status, got.info);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("Mismatch: expected byte %02h frame %0b last %0b status %0d info %08h",
                     want.data, want.frame_byte, want.last, want.status, want.info);
            $display("          got      byte %02h frame %0b last %0b status %0d info %08h",
                     got.data, got.frame_byte, got.last, got.status, got.info);
          end
        end
      end
      if (got.last) begin
        case (got.status)
          psdc_pkg::ST_OK:       frames_closed++;
          psdc_pkg::ST_CHECKSUM: begin
            frames_closed++;
            checksum_errors++;
          end
          psdc_pkg::ST_BAD_SIZE: size_errors++;
          default:               init_errors++;
        endcase
      end
    end
  end

  // Directed script: reset values, a bad init word, size limits, the shortest frame.
  row_t directed_rows [21] = '{
    '{ROW_BYTE, 8'hFF, 1'b0, 32'h0, 1'b1, '{8'hFF, 1'b0, 1'b0, psdc_pkg::ST_OK, 32'h0}},
    '{ROW_BYTE, 8'hFF, 1'b0, 32'h0, 1'b1, '{8'hFF, 1'b0, 1'b0, psdc_pkg::ST_OK, 32'h0}},
    '{ROW_BYTE, 8'hFF, 1'b0, 32'h0, 1'b1, '{8'hFF, 1'b0, 1'b0, psdc_pkg::ST_OK, 32'h0}},
    '{ROW_BYTE, 8'hFF, 1'b0, 32'h0, 1'b1,
      '{8'hFF, 1'b0, 1'b1, psdc_pkg::ST_BAD_INIT, 32'hFFFF_FFFF}},
    '{ROW_CFG,  8'h00, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h0B, 1'b0, 32'h0, 1'b1, '{8'h0B, 1'b1, 1'b0, psdc_pkg::ST_OK, 32'h0}},
    '{ROW_BYTE, 8'h00, 1'b0, 32'h0, 1'b1, '{8'h00, 1'b1, 1'b1, psdc_pkg::ST_BAD_SIZE, 32'd11}},
    '{ROW_BYTE, 8'h00, 1'b0, 32'h0, 1'b1, '{8'h00, 1'b1, 1'b0, psdc_pkg::ST_OK, 32'h0}},
    '{ROW_BYTE, 8'h20, 1'b0, 32'h0, 1'b1,
      '{8'h20, 1'b1, 1'b1, psdc_pkg::ST_BAD_SIZE, 32'd8192}},
    '{ROW_BYTE, 8'h0C, 1'b0, 32'h0, 1'b1, '{8'h0C, 1'b1, 1'b0, psdc_pkg::ST_OK, 32'h0}},
    '{ROW_BYTE, 8'h00, 1'b0, 32'h0, 1'b1, '{8'h00, 1'b1, 1'b0, psdc_pkg::ST_OK, 32'h0}},
    '{ROW_BYTE, 8'hFF, 1'b0, 32'h0, 1'b1, '{8'hFF, 1'b1, 1'b0, psdc_pkg::ST_OK, 32'h0}},
    '{ROW_BYTE, 8'h00, 1'b0, 32'h0, 1'b1, '{8'h00, 1'b1, 1'b0, psdc_pkg::ST_OK, 32'h0}},
    '{ROW_BYTE, 8'h00, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hFF, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h00, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hFF, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h80, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h7F, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h01, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hFE, 1'b0, 32'h0, 1'b0, NO_RESULT}
  };

  initial begin : stimulus
    logic [31:0] code;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part; typed rows still advance the predictor.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_config(directed_rows[i].need, directed_rows[i].code);
      end else if (directed_rows[i].typed) begin
        void'(decode_byte(directed_rows[i].data));
        drive_byte(directed_rows[i].data, directed_rows[i].want);
      end else begin
        send_byte(directed_rows[i].data);
      end
    end

    // Before the init word is accepted: wrong words, frames and mode changes mid-stream.
    for (int p = 0; p < 4; p++) begin
      in_gaps = $urandom_range(0, 2) != 0;
      out_stalls = $urandom_range(0, 2) != 0;
      code = (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'h0 : $urandom;
      write_config(p % 2 == 0, code);
      run_phase(60, $urandom_range(0, 1) == 1);
    end

    // The right init word, after which frames, bad sizes and noise follow.
    write_config(1'b1, $urandom);
    resync();
    for (int i = 0; i < 4; i++) send_byte(code_cfg[8*i +: 8]);
    run_phase(40, 1'b0);

    // Main stream under changing settings.
    for (int p = 0; p < 9; p++) begin
      in_gaps = (p != 8) && $urandom_range(0, 2) != 0;
      out_stalls = (p != 8) && $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 2))
        0:       code = 32'h0;
        1:       code = 32'hFFFF_FFFF;
        default: code = $urandom;
      endcase
      write_config($urandom_range(0, 1) == 1, code);
      run_phase(110, p != 8 && $urandom_range(0, 2) == 0);
    end

    wait_drained(8);
    $display("Sent %0d bytes under %0d register settings; %0d frames closed, %0d of them bad.",
             sent_bytes, settings_count, frames_closed, checksum_errors);
    $display("Flagged %0d bad frame sizes and %0d wrong init words; %0d faults found.",
             size_errors, init_errors, fault_count);
    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a stalled handshake.
  initial begin
    #(RUN_LIMIT);
    $display("Run limit reached with %0d results outstanding.", expected_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
src/psdc_pkg.sv
src/psdc_ram.sv
src/psdc_parse.sv
src/psdc_dec.sv
src/packet_stream_decrypt_check.sv
verif/packet_stream_decrypt_check_test.sv
